@@ design/oef_pkg.sv @@
package oef_pkg;

  localparam int AXES_DEF   = 3;
  localparam int COORD_W    = 32;
  localparam int DIV_NW     = 49;      // dividend / quotient width of the divider
  localparam int DIV_DW     = 33;      // divisor width
  localparam int ACC_W      = 50;
  localparam int TWO_PI_Q16 = 411775;
  localparam int ONE_Q16    = 65536;

  localparam logic [1:0] REG_MIN_CUTOFF   = 2'd0;
  localparam logic [1:0] REG_CUTOFF_SLOPE = 2'd1;
  localparam logic [1:0] REG_DELTA_CUTOFF = 2'd2;

  localparam logic [31:0] RST_MIN_CUTOFF   = 32'd65536;
  localparam logic [31:0] RST_CUTOFF_SLOPE = 32'd459;
  localparam logic [31:0] RST_DELTA_CUTOFF = 32'd65536;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_FIRST,
    OP_P_RATE,
    OP_P_CUT,
    OP_K,
    OP_ADIV,
    OP_ARATE_ST,
    OP_ALPHA_ST,
    OP_RDIV,
    OP_RZERO,
    OP_RATE_ST,
    OP_B1,
    OP_B2,
    OP_EST_ST,
    OP_CUT,
    OP_X1,
    OP_X2,
    OP_LAST_ST,
    OP_OUT
  } oef_op_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_FIRST,
    ST_AP,
    ST_AK,
    ST_AD,
    ST_AW,
    ST_RS,
    ST_RW,
    ST_B1,
    ST_B2,
    ST_BE,
    ST_CT,
    ST_CP,
    ST_CK,
    ST_CD,
    ST_CW,
    ST_X1,
    ST_X2,
    ST_XL,
    ST_OUT
  } oef_state_t;

  typedef struct packed {
    oef_op_t op;
  } oef_cmd_t;

  typedef struct packed {
    logic first;
    logic div_done;
    logic dt_zero;
    logic last_axis;
    logic out_free;
  } oef_stat_t;

  // Q16 division of a signed sum, truncated toward zero
  function automatic logic signed [31:0] oef_trunc16(input logic signed [ACC_W-1:0] s);
    logic signed [ACC_W-1:0] adj;
    adj = s + (s[ACC_W-1] ? ACC_W'(65535) : ACC_W'(0));
    return adj[47:16];
  endfunction

endpackage

@@ design/one_euro_vector_filter.sv @@
// One-euro adaptive smoother for an AXES-dimensional Q16.16 position.
// Input stream: one transfer per sample, in_tdata = sample per axis, then
// delta_time. Output stream: one transfer per sample, the filtered position.
// Config channel: cfg_index 0 min_cutoff, 1 cutoff_slope, 2 delta_cutoff;
// cfg_ready is always high, other indexes are dropped. Write only when idle.
// One sample is in work at a time. The first sample after reset passes
// through. Every later sample uses the shared restoring divider over 49
// bits, once for the rate alpha and twice per axis (raw rate and output
// alpha); with a zero time step the raw-rate division is skipped.
// The result sits in an output register; the next sample is accepted while
// it waits. If the receiver stalls, the finished sample after that holds in
// the datapath until the register frees, and in_tready stays low meanwhile.
// Reset (rst_n low, synchronous) restores the register defaults, drops any
// pending result and makes the next sample a pass-through again.
module one_euro_vector_filter
  import oef_pkg::*;
#(
  parameter int AXES = AXES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [AXES*32+31:0] in_tdata,   // sample per axis (x, y, z...), delta_time
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [AXES*32-1:0]  out_tdata,  // filtered per axis (x, y, z...)
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  oef_cmd_t  cmd;
  oef_stat_t stat;

  assign cfg_ready = 1'b1;

  oef_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  oef_dp #(.AXES(AXES)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

@@ design/oef_div.sv @@
module oef_div
  import oef_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] dividend,
  input  logic [DIV_DW-1:0] divisor,
  output logic [DIV_NW-1:0] quotient,
  output logic              done
);

  localparam int CNT_W = $clog2(DIV_NW + 1);

  logic [DIV_DW:0]     rem_r, rem_nxt;
  logic [DIV_NW-1:0]   quo_r, quo_nxt;
  logic [DIV_DW-1:0]   dvs_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r, done_r;
  logic [DIV_DW:0]     rem_sh;
  logic                ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_r[DIV_DW-1:0], quo_r[DIV_NW-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_nxt = ge ? rem_sh - {1'b0, dvs_r} : rem_sh;
    quo_nxt = {quo_r[DIV_NW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

@@ design/oef_dp.sv @@
module oef_dp
  import oef_pkg::*;
#(
  parameter int AXES = AXES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [AXES*32+31:0]     in_tdata,
  input  logic                    cfg_valid,
  input  logic [1:0]              cfg_index,
  input  logic [31:0]             cfg_data,
  input  logic                    out_tready,
  output logic                    out_tvalid,
  output logic [AXES*32-1:0]      out_tdata,
  input  oef_cmd_t                cmd,
  output oef_stat_t               stat
);

  localparam int AX_W = (AXES > 1) ? $clog2(AXES) : 1;

  logic [31:0]               min_cut_r, slope_r, dcut_r, dt_r;
  logic signed [31:0]        x_r [AXES];
  logic signed [31:0]        last_r [AXES];
  logic signed [31:0]        est_r [AXES];
  logic                      first_r;
  logic [AX_W-1:0]           ax_r;
  logic [15:0]               arate_r, alpha_r;
  logic [31:0]               p_r, k_r, cut_r;
  logic signed [31:0]        rate_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      sign_r;
  logic                      out_valid_r;
  logic [AXES*32-1:0]        out_data_r;

  logic signed [31:0]        x_cur, last_cur, est_cur;
  logic signed [32:0]        diff;
  logic [32:0]               mag;
  logic [31:0]               est_mag;
  logic signed [32:0]        mul_a, mul_b;
  logic signed [65:0]        prod;
  logic [31:0]               prod_sat;
  logic [48:0]               cut_sum;
  logic signed [ACC_W-1:0]   acc_sum;
  logic [DIV_NW-1:0]         div_dividend, div_q;
  logic [DIV_DW-1:0]         div_divisor;
  logic                      div_start, div_done;
  logic signed [31:0]        rate_sat;

  always_comb begin
    x_cur    = x_r[ax_r];
    last_cur = last_r[ax_r];
    est_cur  = est_r[ax_r];
    diff     = {x_cur[31], x_cur} - {last_cur[31], last_cur};
    mag      = diff[32] ? 33'(-diff) : 33'(diff);
    est_mag  = est_cur[31] ? 32'(-est_cur) : 32'(est_cur);
  end

  // one shared multiplier, operands picked per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_P_RATE: begin mul_a = {1'b0, dcut_r};  mul_b = {1'b0, dt_r}; end
      OP_P_CUT:  begin mul_a = {1'b0, cut_r};   mul_b = {1'b0, dt_r}; end
      OP_K:      begin mul_a = {1'b0, p_r};     mul_b = 33'(TWO_PI_Q16); end
      OP_B1:     begin mul_a = {17'b0, arate_r}; mul_b = {rate_r[31], rate_r}; end
      OP_B2:     begin
        mul_a = 33'(ONE_Q16) - {17'b0, arate_r};
        mul_b = {est_cur[31], est_cur};
      end
      OP_CUT:    begin mul_a = {1'b0, slope_r}; mul_b = {1'b0, est_mag}; end
      OP_X1:     begin mul_a = {17'b0, alpha_r}; mul_b = {x_cur[31], x_cur}; end
      OP_X2:     begin
        mul_a = 33'(ONE_Q16) - {17'b0, alpha_r};
        mul_b = {last_cur[31], last_cur};
      end
      default: ;
    endcase
  end

  always_comb begin
    prod     = mul_a * mul_b;
    prod_sat = (|prod[63:48]) ? 32'hFFFF_FFFF : prod[47:16];
    cut_sum  = {17'b0, min_cut_r} + {1'b0, prod[63:16]};
    acc_sum  = acc_r + $signed(prod[ACC_W-1:0]);
  end

  always_comb begin
    div_start = (cmd.op == OP_ADIV) || (cmd.op == OP_RDIV);
    if (cmd.op == OP_ADIV) begin
      div_dividend = {1'b0, k_r, 16'h0000};
      div_divisor  = {1'b0, k_r} + 33'(ONE_Q16);
    end else begin
      div_dividend = {mag, 16'h0000};
      div_divisor  = {1'b0, dt_r};
    end
  end

  oef_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .done     (div_done)
  );

  always_comb begin
    if (sign_r)
      rate_sat = (div_q > DIV_NW'(32'h8000_0000)) ? 32'sh8000_0000 : 32'(-div_q[31:0]);
    else
      rate_sat = (div_q > DIV_NW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : 32'(div_q[31:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_cut_r   <= RST_MIN_CUTOFF;
      slope_r     <= RST_CUTOFF_SLOPE;
      dcut_r      <= RST_DELTA_CUTOFF;
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_MIN_CUTOFF)   min_cut_r <= cfg_data;
        if (cfg_index == REG_CUTOFF_SLOPE) slope_r   <= cfg_data;
        if (cfg_index == REG_DELTA_CUTOFF) dcut_r    <= cfg_data;
      end
      if (cmd.op == OP_FIRST) first_r <= 1'b0;
      if (cmd.op == OP_OUT)
        out_valid_r <= 1'b1;
      else if (out_tready)
        out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        for (int i = 0; i < AXES; i++) x_r[i] <= in_tdata[i*32 +: 32];
        dt_r <= in_tdata[AXES*32 +: 32];
        ax_r <= '0;
      end
      OP_FIRST: begin
        for (int i = 0; i < AXES; i++) begin
          last_r[i] <= x_r[i];
          est_r[i]  <= '0;
        end
      end
      OP_P_RATE, OP_P_CUT: p_r <= prod_sat;
      OP_K:        k_r     <= prod_sat;
      OP_ARATE_ST: arate_r <= div_q[15:0];
      OP_ALPHA_ST: alpha_r <= div_q[15:0];
      OP_RDIV:     sign_r  <= diff[32];
      OP_RZERO:    rate_r  <= '0;
      OP_RATE_ST:  rate_r  <= rate_sat;
      OP_B1, OP_X1: acc_r  <= $signed(prod[ACC_W-1:0]);
      OP_B2, OP_X2: acc_r  <= acc_sum;
      OP_EST_ST:   est_r[ax_r] <= oef_trunc16(acc_r);
      OP_CUT:      cut_r <= (|cut_sum[48:32]) ? 32'hFFFF_FFFF : cut_sum[31:0];
      OP_LAST_ST: begin
        last_r[ax_r] <= oef_trunc16(acc_r);
        ax_r         <= ax_r + 1'b1;
      end
      OP_OUT: begin
        for (int i = 0; i < AXES; i++) out_data_r[i*32 +: 32] <= last_r[i];
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    stat.first     = first_r;
    stat.div_done  = div_done;
    stat.dt_zero   = (dt_r == '0);
    stat.last_axis = (ax_r == AX_W'(AXES - 1));
    stat.out_free  = !out_valid_r || out_tready;
  end

endmodule

@@ design/oef_ctrl.sv @@
module oef_ctrl
  import oef_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  oef_stat_t stat,
  output oef_cmd_t  cmd
);

  oef_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = stat.first ? ST_FIRST : ST_AP;
      ST_FIRST: state_nxt = ST_OUT;
      ST_AP:    state_nxt = ST_AK;
      ST_AK:    state_nxt = ST_AD;
      ST_AD:    state_nxt = ST_AW;
      ST_AW:    if (stat.div_done) state_nxt = ST_RS;
      ST_RS:    state_nxt = stat.dt_zero ? ST_B1 : ST_RW;
      ST_RW:    if (stat.div_done) state_nxt = ST_B1;
      ST_B1:    state_nxt = ST_B2;
      ST_B2:    state_nxt = ST_BE;
      ST_BE:    state_nxt = ST_CT;
      ST_CT:    state_nxt = ST_CP;
      ST_CP:    state_nxt = ST_CK;
      ST_CK:    state_nxt = ST_CD;
      ST_CD:    state_nxt = ST_CW;
      ST_CW:    if (stat.div_done) state_nxt = ST_X1;
      ST_X1:    state_nxt = ST_X2;
      ST_X2:    state_nxt = ST_XL;
      ST_XL:    state_nxt = stat.last_axis ? ST_OUT : ST_RS;
      ST_OUT:   if (stat.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmd.op    = OP_NONE;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) cmd.op = OP_LOAD;
      end
      ST_FIRST: cmd.op = OP_FIRST;
      ST_AP:    cmd.op = OP_P_RATE;
      ST_AK:    cmd.op = OP_K;
      ST_AD:    cmd.op = OP_ADIV;
      ST_AW:    if (stat.div_done) cmd.op = OP_ARATE_ST;
      ST_RS:    cmd.op = stat.dt_zero ? OP_RZERO : OP_RDIV;
      ST_RW:    if (stat.div_done) cmd.op = OP_RATE_ST;
      ST_B1:    cmd.op = OP_B1;
      ST_B2:    cmd.op = OP_B2;
      ST_BE:    cmd.op = OP_EST_ST;
      ST_CT:    cmd.op = OP_CUT;
      ST_CP:    cmd.op = OP_P_CUT;
      ST_CK:    cmd.op = OP_K;
      ST_CD:    cmd.op = OP_ADIV;
      ST_CW:    if (stat.div_done) cmd.op = OP_ALPHA_ST;
      ST_X1:    cmd.op = OP_X1;
      ST_X2:    cmd.op = OP_X2;
      ST_XL:    cmd.op = OP_LAST_ST;
      ST_OUT:   if (stat.out_free) cmd.op = OP_OUT;
      default:  cmd.op = OP_NONE;
    endcase
  end

endmodule

@@ design/oef_checker.sv @@
module oef_checker
  import oef_pkg::*;
#(
  parameter int AXES = AXES_DEF
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_tvalid,
  input logic                in_tready,
  input logic                out_tvalid,
  input logic                out_tready,
  input logic [AXES*32-1:0]  out_tdata,
  input logic                cfg_ready
);

  // stalled result must hold
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed under stall");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("reset did not clear the block");

  // one sample at a time: no transfer in the cycle after one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("config channel not ready");

endmodule

bind one_euro_vector_filter oef_checker #(.AXES(AXES)) u_oef_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_ready  (cfg_ready)
);
